@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, also while reset is held.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

// Checked only while reset is released.
`define ASSERT_ACTIVE(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`endif

@@ rtl/hssc_pkg.sv @@
package hssc_pkg;

    localparam int unsigned DutyW = 11;
    localparam int unsigned PosW  = 32;

    localparam logic [0:0]       CMD_HALL = 1'b0;
    localparam logic [0:0]       CMD_DUTY = 1'b1;
    localparam logic [1:0]       STEP_NONE = 2'd0;
    localparam logic [1:0]       STEP_FWD  = 2'd1;
    localparam logic [1:0]       STEP_BWD  = 2'd2;
    localparam logic [DutyW-1:0] DUTY_MAX = 11'd1199;
    localparam logic [DutyW-1:0] MIN_DUTY_RESET = 11'd100;
    localparam logic [2:0]       LOW_ALL_OFF = 3'b111;
    localparam logic [2:0]       LOW_ALL_ON  = 3'b000;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BWD  = 2'd2
    } t_dir;

    localparam logic [15:0] FWD_ENABLE [8] = '{16'h3000, 16'h3400, 16'h3004, 16'h3400,
                                              16'h3040, 16'h3040, 16'h3004, 16'h3000};
    localparam logic [2:0]  FWD_LOW [8]    = '{3'd7, 3'd6, 3'd5, 3'd5, 3'd3, 3'd6, 3'd3, 3'd7};
    localparam logic [15:0] BWD_ENABLE [8] = '{16'h3000, 16'h3004, 16'h3040, 16'h3040,
                                              16'h3400, 16'h3004, 16'h3400, 16'h3000};
    localparam logic [2:0]  BWD_LOW [8]    = '{3'd7, 3'd3, 3'd6, 3'd3, 3'd5, 3'd5, 3'd6, 3'd7};
    // Hall code that comes before each code in a forward and in a backward step.
    localparam logic [2:0]  PREV_FWD [8]   = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd0};
    localparam logic [2:0]  PREV_BWD [8]   = '{3'd0, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1, 3'd4, 3'd0};

    typedef struct packed {
        logic [0:0]        cmd;
        logic [2:0]        hall_code;
        logic signed [11:0] drive_level;
        logic              stop_request;
    } t_item;

    typedef struct packed {
        logic              running;
        logic [1:0]        step_seen;
        logic [PosW-1:0]   position;
        logic [DutyW-1:0]  duty;
        logic [2:0]        low_side_lines;
        logic [15:0]       enable_word;
    } t_result;

endpackage

@@ rtl/hssc_core.sv @@
module hssc_core import hssc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DutyW-1:0] i_cfg_wdata,
    input  logic             i_fire,
    input  t_item            i_item,
    output t_result          o_result
);

    logic [DutyW-1:0] r_min_duty;
    logic [2:0]       r_last_hall;
    logic [PosW-1:0]  r_position;
    t_dir             r_dir;
    logic             r_run;
    logic [15:0]      r_enable;
    logic [2:0]       r_low;
    logic [DutyW-1:0] r_duty;

    logic [2:0]       n_last_hall;
    logic [PosW-1:0]  n_position;
    t_dir             n_dir;
    logic             n_run;
    logic [15:0]      n_enable;
    logic [2:0]       n_low;
    logic [DutyW-1:0] n_duty;
    logic [1:0]       step;

    logic             hall_valid;
    logic             neg;
    logic [12:0]      mag_raw;
    logic [12:0]      mag_min;
    logic [12:0]      mag;

    assign hall_valid = (i_item.hall_code != 3'd0) && (i_item.hall_code != 3'd7);
    assign neg        = i_item.drive_level[11];
    assign mag_raw    = neg ? 13'(13'd0 - {i_item.drive_level[11], i_item.drive_level})
                            : {1'b0, i_item.drive_level};
    assign mag_min    = (mag_raw < {2'b00, r_min_duty}) ? {2'b00, r_min_duty} : mag_raw;
    assign mag        = (mag_min > {2'b00, DUTY_MAX}) ? {2'b00, DUTY_MAX} : mag_min;

    always_comb begin
        t_dir pat_dir;
        pat_dir     = r_dir;
        n_last_hall = r_last_hall;
        n_position  = r_position;
        n_dir       = r_dir;
        n_run       = r_run;
        n_enable    = r_enable;
        n_low       = r_low;
        n_duty      = r_duty;
        step        = STEP_NONE;
        if (i_item.cmd == CMD_HALL) begin
            if (hall_valid) begin
                case (r_dir)
                    DIR_FWD: begin
                        n_enable = FWD_ENABLE[i_item.hall_code];
                        n_low    = FWD_LOW[i_item.hall_code];
                    end
                    DIR_BWD: begin
                        n_enable = BWD_ENABLE[i_item.hall_code];
                        n_low    = BWD_LOW[i_item.hall_code];
                    end
                    default: ;
                endcase
                if (r_last_hall == PREV_FWD[i_item.hall_code]) begin
                    n_position = r_position + 32'd1;
                    step       = STEP_FWD;
                end else if (r_last_hall == PREV_BWD[i_item.hall_code]) begin
                    n_position = r_position - 32'd1;
                    step       = STEP_BWD;
                end
                n_last_hall = i_item.hall_code;
            end
        end else if (i_item.stop_request) begin
            n_enable = 16'h0000;
            n_low    = LOW_ALL_ON;
            n_run    = 1'b0;
        end else if (i_item.drive_level == 12'sd0) begin
            n_enable = 16'h0000;
            n_low    = LOW_ALL_ON;
            n_duty   = '0;
        end else begin
            pat_dir = neg ? DIR_BWD : DIR_FWD;
            n_dir   = pat_dir;
            n_duty  = mag[DutyW-1:0];
            if (!r_run && hall_valid) begin
                n_run = 1'b1;
                if (pat_dir == DIR_FWD) begin
                    n_enable = FWD_ENABLE[i_item.hall_code];
                    n_low    = FWD_LOW[i_item.hall_code];
                end else begin
                    n_enable = BWD_ENABLE[i_item.hall_code];
                    n_low    = BWD_LOW[i_item.hall_code];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty  <= MIN_DUTY_RESET;
            r_last_hall <= 3'd0;
            r_position  <= '0;
            r_dir       <= DIR_BWD;
            r_run       <= 1'b0;
            r_enable    <= 16'h0000;
            r_low       <= LOW_ALL_OFF;
            r_duty      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_duty <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_last_hall <= n_last_hall;
                r_position  <= n_position;
                r_dir       <= n_dir;
                r_run       <= n_run;
                r_enable    <= n_enable;
                r_low       <= n_low;
                r_duty      <= n_duty;
            end
        end
    end

    assign o_result.running        = n_run;
    assign o_result.step_seen      = step;
    assign o_result.position       = n_position;
    assign o_result.duty           = n_duty;
    assign o_result.low_side_lines = n_low;
    assign o_result.enable_word    = n_enable;

endmodule

@@ rtl/hssc_out_reg.sv @@
module hssc_out_reg import hssc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    output logic        o_ready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // enable_word, low_side_lines, duty, position, step_seen, running, zero fill
    output logic [71:0] m_axis_tdata
);

    logic       r_valid;
    t_result    r_result;

    assign o_ready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r_result};

endmodule

@@ rtl/hall_six_step_commutator.sv @@
// Six-step commutator for a three-phase motor with three hall sensors.
// The slave channel carries one request per hall edge or duty update:
// tuser is the command (hall edge or duty update) and tdata holds the hall
// code, the signed drive level and the stop flag. The master channel returns
// exactly one result per request: enable word, low-side lines, duty, position,
// step seen and run flag, reflecting the state after that request.
// The min_duty register is written through i_cfg_we and i_cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce this.
// A request is held in the input register, is worked through in a single pass
// of table lookups, a clamp and the position adder, and lands in the output
// register, whose tvalid rises once it is loaded.
// Throughput is one request per cycle, set by the output register being
// reloaded every cycle while the receiver takes results.
// When the receiver stalls, the result is held, the input register fills and
// tready falls; nothing is lost. Synchronous reset clears both stages and
// returns the state to stopped, backward direction, low sides off, duty 0.
module hall_six_step_commutator import hssc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DutyW-1:0] i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // hall_code, drive_level, stop_request
    input  logic [15:0]      s_axis_tdata,
    // cmd
    input  logic [0:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // enable_word, low_side_lines, duty, position, step_seen, running, zero fill
    output logic [71:0]      m_axis_tdata
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    out_ready;
    logic    fire;
    t_result result;

    assign fire          = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.cmd          <= s_axis_tuser;
            r_in_item.hall_code    <= s_axis_tdata[2:0];
            r_in_item.drive_level  <= $signed(s_axis_tdata[14:3]);
            r_in_item.stop_request <= s_axis_tdata[15];
        end
    end

    hssc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .o_result    (result)
    );

    hssc_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire),
        .i_result      (result),
        .o_ready       (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ rtl/hssc_checker.sv @@
`include "assert_macros.svh"

module hssc_checker import hssc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic [DutyW-1:0] i_cfg_wdata,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [15:0]      s_axis_tdata,
    input logic [0:0]       s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [71:0]      m_axis_tdata
);

    `ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `ASSERT_ACTIVE(a_stall_holds, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_ACTIVE(a_step_code, i_clk, i_rst_n,
        m_axis_tvalid |-> m_axis_tdata[63:62] != 2'd3)
    `ASSERT_ACTIVE(a_duty_range, i_clk, i_rst_n,
        m_axis_tvalid |-> m_axis_tdata[29:19] <= DUTY_MAX)
    // With every phase disabled the low sides are either all braking or all off.
    `ASSERT_ACTIVE(a_brake_lines, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[15:0] == 16'h0000 |->
            m_axis_tdata[18:16] == LOW_ALL_ON || m_axis_tdata[18:16] == LOW_ALL_OFF)

endmodule

bind hall_six_step_commutator hssc_checker u_hssc_checker (.*);
